// File: design/b64e_pkg.sv
// Shared types, constants and the character lookup for the base64 stream encoder.
package b64e_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR  = 8'h3D;   // '='
    localparam logic [7:0] TERM_CHAR = 8'h00;

    localparam logic [2:0] QUAD_LEN   = 3'd4;
    localparam logic [2:0] SEXT_FULL  = 3'd4;
    localparam logic [2:0] SEXT_TWO_B = 3'd3;
    localparam logic [2:0] SEXT_ONE_B = 3'd2;

    // One queued request: the four-character quad (if any), then the terminator
    // (if any); n_ok characters go out before the optional failure result.
    typedef struct packed {
        logic [23:0] group;
        logic        quad;
        logic [2:0]  n_sextets;
        logic        term;
        logic [2:0]  n_ok;
        logic        fail;
    } b64e_cmd_t;

    function automatic logic [7:0] b64e_char(input logic [5:0] v);
        logic [7:0] c;
        c = {2'b00, v};
        if (v < 6'd26)
            return 8'h41 + c;
        else if (v < 6'd52)
            return 8'h61 + c - 8'd26;
        else if (v < 6'd62)
            return 8'h30 + c - 8'd52;
        else if (v == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

endpackage

// File: design/b64e_front.sv
// Front end: byte grouping, message state and capacity check per request.
module b64e_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [15:0]         cfg_data,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                has_byte,
    input  logic                last_byte,
    output logic                push,
    output b64e_pkg::b64e_cmd_t push_cmd
);
    import b64e_pkg::*;

    logic [15:0] cap_reg;
    logic [15:0] held_reg, held_next;
    logic [1:0]  fill_reg, fill_next;
    logic [15:0] count_reg, count_next;
    logic        ovf_reg, ovf_next;

    logic [15:0] held_a;
    logic [1:0]  fill_a;
    logic [2:0]  npend;
    logic [15:0] room;
    b64e_cmd_t   cmd;

    always_comb
    begin
        held_next  = held_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        held_a     = held_reg;
        fill_a     = fill_reg;
        cmd        = '0;
        npend      = '0;
        room       = '0;
        push       = 1'b0;

        // group stage: absorb the byte
        if (has_byte)
        begin
            unique case (fill_reg)
                2'd0:
                begin
                    held_a = {data_byte, 8'h00};
                    fill_a = 2'd1;
                end
                2'd1:
                begin
                    held_a = {held_reg[15:8], data_byte};
                    fill_a = 2'd2;
                end
                default:
                begin
                    cmd.quad      = 1'b1;
                    cmd.group     = {held_reg, data_byte};
                    cmd.n_sextets = SEXT_FULL;
                    held_a        = '0;
                    fill_a        = 2'd0;
                end
            endcase
        end

        // flush on the marked last item
        if (last_byte)
        begin
            cmd.term = 1'b1;
            if (fill_a == 2'd1)
            begin
                cmd.quad      = 1'b1;
                cmd.group     = {held_a, 8'h00};
                cmd.n_sextets = SEXT_ONE_B;
            end
            else if (fill_a == 2'd2)
            begin
                cmd.quad      = 1'b1;
                cmd.group     = {held_a, 8'h00};
                cmd.n_sextets = SEXT_TWO_B;
            end
        end

        npend    = (cmd.quad ? QUAD_LEN : 3'd0) + {2'b00, cmd.term};
        room     = (count_reg >= cap_reg) ? 16'd0 : cap_reg - count_reg;
        cmd.fail = ({13'd0, npend} > room);
        cmd.n_ok = cmd.fail ? room[2:0] : npend;

        if (accept)
        begin
            if (ovf_reg)
            begin
                if (last_byte)
                begin
                    held_next  = '0;
                    fill_next  = '0;
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            else
            begin
                push       = (npend != 3'd0);
                held_next  = held_a;
                fill_next  = fill_a;
                count_next = count_reg + {13'd0, cmd.n_ok};
                if (last_byte)
                begin
                    held_next  = '0;
                    fill_next  = '0;
                    count_next = '0;
                end
                else if (cmd.fail)
                begin
                    ovf_next = 1'b1;
                end
            end
        end
    end

    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= 16'hFFFF;
            held_reg  <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                cap_reg <= cfg_data;
            held_reg  <= held_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// File: design/b64e_queue.sv
// Short request queue between the front end and the character emitter.
module b64e_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64e_pkg::b64e_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output b64e_pkg::b64e_cmd_t head_cmd
);
    import b64e_pkg::*;

    b64e_cmd_t              mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    assign full       = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            cnt_reg <= cnt_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

endmodule

// File: design/b64e_back.sv
// Back end: walks one queued request a character per cycle into the output register unless stalled.
module b64e_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  b64e_pkg::b64e_cmd_t head_cmd,
    output logic                pop,
    output logic                char_valid,
    input  logic                char_stall,
    output logic [7:0]          out_char,
    output logic                end_of_run,
    output logic                status
);
    import b64e_pkg::*;

    logic [2:0] k_reg, k_next;
    logic       ov_reg;
    logic [7:0] char_reg;
    logic       eor_reg, st_reg;

    logic [7:0] c_d;
    logic       eor_d, st_d, last_d, emit;
    logic [5:0] sx;

    always_comb
    begin
        c_d    = TERM_CHAR;
        eor_d  = 1'b1;
        st_d   = 1'b0;
        last_d = 1'b1;
        unique case (k_reg[1:0])
            2'd0:    sx = head_cmd.group[23:18];
            2'd1:    sx = head_cmd.group[17:12];
            2'd2:    sx = head_cmd.group[11:6];
            default: sx = head_cmd.group[5:0];
        endcase
        if (head_cmd.fail && (k_reg == head_cmd.n_ok))
        begin
            st_d = 1'b1;
        end
        else if (head_cmd.quad && (k_reg < QUAD_LEN))
        begin
            c_d    = (k_reg < head_cmd.n_sextets) ? b64e_char(sx) : PAD_CHAR;
            eor_d  = 1'b0;
            last_d = !head_cmd.fail && ((k_reg + 3'd1) == head_cmd.n_ok);
        end
    end

    assign emit = head_valid && (!ov_reg || !char_stall);
    assign pop  = emit && last_d;

    always_comb
    begin
        k_next = k_reg;
        if (pop)
            k_next = '0;
        else if (emit)
            k_next = k_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (!char_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            char_reg <= c_d;
            eor_reg  <= eor_d;
            st_reg   <= st_d;
        end
    end

    assign char_valid = ov_reg;
    assign out_char   = char_reg;
    assign end_of_run = eor_reg;
    assign status     = st_reg;

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= 3'd5)
        else $error("character index out of range");
    a_k_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg != 3'd0) |-> head_valid)
        else $error("request walk in progress with empty queue");
    a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && status) |-> (end_of_run && out_char == TERM_CHAR))
        else $error("failure result malformed");

endmodule

// File: design/base64_stream_encoder.sv
// Top level of the streaming base64 encoder with output capacity check.
//
// Message bytes come in one per accepted request on the data channel and
// leave as base64 characters (standard alphabet, '=' padding) one per
// accepted request on the char channel, followed by a zero terminator with
// end_of_run set when last_byte is seen. Every character, terminator
// included, counts against cfg_data as written by cfg_write (reset 65535);
// when the count would pass it, one failure result (char 0, end_of_run 1,
// status 1) ends the message and bytes up to the next last_byte are
// dropped. Rate: the front end takes one request per cycle while its
// two-entry queue has room; the back end sends one character per cycle
// while char_stall is low; a byte closing a group yields four characters
// and a last request up to five. Results are held in an output register,
// so input keeps flowing while char_stall is high until the queue fills.
// Write the capacity only while no message is in flight.
module base64_stream_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last_byte,
    output logic        char_valid,
    input  logic        char_stall,
    output logic [7:0]  out_char,
    output logic        end_of_run,
    output logic        status
);
    import b64e_pkg::*;

    logic      accept;
    logic      push, pop, full, head_valid;
    b64e_cmd_t push_cmd, head_cmd;

    // stall only on a full queue; the front state advances per accepted request
    assign data_stall = full;
    assign accept     = data_valid && !full;

    b64e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .last_byte (last_byte),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    b64e_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .out_char   (out_char),
        .end_of_run (end_of_run),
        .status     (status)
    );

endmodule
